### hdl/cfb_pkg.sv
package cfb_pkg;

  localparam logic [7:0] SOF_BYTE = 8'h12;
  localparam logic [7:0] EOF_BYTE = 8'h13;
  localparam logic [7:0] CRC_POLY = 8'hD5;
  localparam logic [7:0] CRC_INIT = 8'h00;

  localparam int unsigned POS_W = 3;

  localparam logic [POS_W-1:0] POS_SOF  = 3'd0;
  localparam logic [POS_W-1:0] POS_ADDR = 3'd1;
  localparam logic [POS_W-1:0] POS_CMD  = 3'd2;
  localparam logic [POS_W-1:0] POS_ARG1 = 3'd3;
  localparam logic [POS_W-1:0] POS_ARG2 = 3'd4;
  localparam logic [POS_W-1:0] POS_CRC  = 3'd5;
  localparam logic [POS_W-1:0] POS_EOF  = 3'd6;

  typedef struct packed {
    logic [7:0] dest_address;
    logic [7:0] command_code;
    logic [7:0] argument_one;
    logic [7:0] argument_two;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic       differ;
    crc = crc_in;
    for (int b = 0; b < 8; b++) begin
      differ = crc[0] ^ data[b];
      crc = {1'b0, crc[7:1]};
      if (differ) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

### hdl/cfb_cmd_queue.sv
module cfb_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cfb_pkg::cmd_t in_cmd,
  output cfb_pkg::head_t head,
  input  logic          pop
);

  cfb_pkg::cmd_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign head.valid = (count != 2'd0);
  assign head.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### hdl/cfb_frame_seq.sv
module cfb_frame_seq (
  input  logic           clk,
  input  logic           rst,
  input  cfb_pkg::head_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     frame_byte,
  output logic           last_byte
);

  logic [cfb_pkg::POS_W-1:0] pos;
  logic [cfb_pkg::POS_W-1:0] pos_next;
  logic [7:0] crc;
  logic [7:0] crc_next;
  logic [7:0] byte_sel;
  logic       load;

  assign load = head.valid && (!out_valid || out_ready);
  assign pop  = load && (pos == cfb_pkg::POS_EOF);

  always_comb begin
    case (pos)
      cfb_pkg::POS_SOF:  byte_sel = cfb_pkg::SOF_BYTE;
      cfb_pkg::POS_ADDR: byte_sel = head.cmd.dest_address;
      cfb_pkg::POS_CMD:  byte_sel = head.cmd.command_code;
      cfb_pkg::POS_ARG1: byte_sel = head.cmd.argument_one;
      cfb_pkg::POS_ARG2: byte_sel = head.cmd.argument_two;
      cfb_pkg::POS_CRC:  byte_sel = crc;
      cfb_pkg::POS_EOF:  byte_sel = cfb_pkg::EOF_BYTE;
      default:           byte_sel = cfb_pkg::SOF_BYTE;
    endcase
  end

  always_comb begin
    case (pos)
      cfb_pkg::POS_SOF:  crc_next = cfb_pkg::CRC_INIT;
      cfb_pkg::POS_ADDR,
      cfb_pkg::POS_CMD,
      cfb_pkg::POS_ARG1,
      cfb_pkg::POS_ARG2: crc_next = cfb_pkg::crc_byte(crc, byte_sel);
      default:           crc_next = crc;
    endcase
  end

  assign pos_next = (pos == cfb_pkg::POS_EOF) ? cfb_pkg::POS_SOF : pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= cfb_pkg::POS_SOF;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        pos       <= pos_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      crc        <= crc_next;
      frame_byte <= byte_sel;
      last_byte  <= (pos == cfb_pkg::POS_EOF);
    end
  end

endmodule

### hdl/command_frame_builder_crc8.sv
// Channel | Direction | Handshake          | Word
// command | in        | in_valid/in_ready  | dest_address, command_code, argument_one, argument_two
// frame   | out       | out_valid/out_ready| frame_byte, last_byte
//
// Each command yields seven frame words, one per cycle while out_ready stays high.
// The checksum is built one payload byte per cycle, while the output does not stall, as the payload words leave.
// Reset clears the command queue and the sequencer; no word is pending after it.
// A two-entry command queue lets the input keep accepting while the output stalls.
module command_frame_builder_crc8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] dest_address,
  input  logic [7:0] command_code,
  input  logic [7:0] argument_one,
  input  logic [7:0] argument_two,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_byte,
  output logic       last_byte
);

  cfb_pkg::cmd_t  in_cmd;
  cfb_pkg::head_t head;
  logic           pop;

  assign in_cmd.dest_address = dest_address;
  assign in_cmd.command_code = command_code;
  assign in_cmd.argument_one = argument_one;
  assign in_cmd.argument_two = argument_two;

  cfb_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .head     (head),
    .pop      (pop)
  );

  cfb_frame_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
  );

endmodule

### hdl/cfb_checker.sv
module cfb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] frame_byte,
  input logic       last_byte
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("Block is not idle right after reset.");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("Command word withdrawn before it was taken.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(last_byte))
    else $error("Stalled frame word changed.");

  a_last_is_eof: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte |-> frame_byte == cfb_pkg::EOF_BYTE)
    else $error("Last word is not the end marker.");

  a_next_is_sof: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_byte |=>
      !out_valid || (frame_byte == cfb_pkg::SOF_BYTE && !last_byte))
    else $error("Frame does not open with the start marker.");

endmodule

bind command_frame_builder_crc8 cfb_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .frame_byte (frame_byte),
  .last_byte  (last_byte)
);

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } frame_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] dest_address = 8'h00;
  logic [7:0] command_code = 8'h00;
  logic [7:0] argument_one = 8'h00;
  logic [7:0] argument_two = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] frame_byte;
  logic       last_byte;

  cfb_pkg::cmd_t pending_cmds[$];
  frame_word_t   expected_words[$];

  int errors = 0;
  int accepted_cmds = 0;
  int checked_words = 0;
  int marker_crc_cmds = 0;

  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;

  logic [7:0] rx_pattern = 8'hFF;
  int         rx_cycle = 0;
  int         rx_words = 0;
  bit         hold_done = 1'b0;

  command_frame_builder_crc8 u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .dest_address (dest_address),
    .command_code (command_code),
    .argument_one (argument_one),
    .argument_two (argument_two),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_byte   (frame_byte),
    .last_byte    (last_byte)
  );

  always #5 clk = ~clk;

  // The checksum runs over the 32 payload bits, address bit 0 first.
  function automatic logic [7:0] frame_checksum(input cfb_pkg::cmd_t c);
    logic [31:0] stream;
    logic [7:0]  acc;
    logic        feedback;
    stream = {c.argument_two, c.argument_one, c.command_code, c.dest_address};
    acc = cfb_pkg::CRC_INIT;
    for (int i = 0; i < 32; i++) begin
      feedback = acc[0] ^ stream[i];
      acc = acc >> 1;
      if (feedback) begin
        acc = acc ^ cfb_pkg::CRC_POLY;
      end
    end
    return acc;
  endfunction

  task automatic predict_frame(input cfb_pkg::cmd_t c);
    logic [7:0] frame[7];
    frame_word_t w;
    frame[cfb_pkg::POS_SOF]  = cfb_pkg::SOF_BYTE;
    frame[cfb_pkg::POS_ADDR] = c.dest_address;
    frame[cfb_pkg::POS_CMD]  = c.command_code;
    frame[cfb_pkg::POS_ARG1] = c.argument_one;
    frame[cfb_pkg::POS_ARG2] = c.argument_two;
    frame[cfb_pkg::POS_CRC]  = frame_checksum(c);
    frame[cfb_pkg::POS_EOF]  = cfb_pkg::EOF_BYTE;
    for (int k = 0; k < 7; k++) begin
      w.value = frame[k];
      w.last  = (k == cfb_pkg::POS_EOF);
      expected_words.push_back(w);
    end
  endtask

  function automatic cfb_pkg::cmd_t make_cmd(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c, input logic [7:0] d);
    cfb_pkg::cmd_t r;
    r.dest_address = a;
    r.command_code = b;
    r.argument_one = c;
    r.argument_two = d;
    return r;
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 9))
      0: return cfb_pkg::SOF_BYTE;
      1: return cfb_pkg::EOF_BYTE;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    cfb_pkg::cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 12);
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        c = make_cmd(dest_address, command_code, argument_one, argument_two);
        predict_frame(c);
        accepted_cmds++;
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() > 0 && (gap_left == 0 || hold_left > 0)) begin
          c = pending_cmds.pop_front();
          dest_address <= c.dest_address;
          command_code <= c.command_code;
          argument_one <= c.argument_one;
          argument_two <= c.argument_two;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) begin
            gap_left--;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        rx_words++;
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) begin
        rx_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end else begin
        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
      end
      // After sixty frames the output stops long enough for the command queue to fill.
      if (!hold_done && rx_words >= 420) begin
        hold_done = 1'b1;
        hold_left <= 200;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= rx_pattern[0];
      end
    end
  end

  always @(posedge clk) begin
    frame_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected frame word %h last %b", $time, frame_byte, last_byte);
        errors++;
      end else begin
        w = expected_words.pop_front();
        checked_words++;
        if (frame_byte !== w.value) begin
          $display("%0t: frame_byte expected %h actual %h", $time, w.value, frame_byte);
          errors++;
        end
        if (last_byte !== w.last) begin
          $display("%0t: last_byte expected %b actual %b", $time, w.last, last_byte);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || expected_words.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    cfb_pkg::cmd_t c;
    bit            found_sof;
    bit            found_eof;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    pending_cmds.push_back(make_cmd(8'h00, 8'h00, 8'h00, 8'h00));
    pending_cmds.push_back(make_cmd(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    pending_cmds.push_back(make_cmd(8'hFF, 8'h00, 8'h00, 8'h00));
    pending_cmds.push_back(make_cmd(8'h00, 8'hFF, 8'h00, 8'h00));
    pending_cmds.push_back(make_cmd(8'h00, 8'h00, 8'hFF, 8'h00));
    pending_cmds.push_back(make_cmd(8'h00, 8'h00, 8'h00, 8'hFF));
    pending_cmds.push_back(make_cmd(cfb_pkg::SOF_BYTE, cfb_pkg::EOF_BYTE,
                                    cfb_pkg::SOF_BYTE, cfb_pkg::EOF_BYTE));
    pending_cmds.push_back(make_cmd(cfb_pkg::EOF_BYTE, cfb_pkg::SOF_BYTE,
                                    cfb_pkg::EOF_BYTE, cfb_pkg::SOF_BYTE));
    pending_cmds.push_back(make_cmd(8'h01, 8'h80, 8'h55, 8'hAA));
    pending_cmds.push_back(make_cmd(8'hAA, 8'h55, 8'h80, 8'h01));

    // Commands whose checksum itself equals one of the frame markers.
    found_sof = 1'b0;
    found_eof = 1'b0;
    for (int v = 0; v < 65536; v++) begin
      c = make_cmd(8'h5A, 8'hC3, 8'(v >> 8), 8'(v));
      if (!found_sof && frame_checksum(c) == cfb_pkg::SOF_BYTE) begin
        pending_cmds.push_back(c);
        found_sof = 1'b1;
        marker_crc_cmds++;
      end else if (!found_eof && frame_checksum(c) == cfb_pkg::EOF_BYTE) begin
        pending_cmds.push_back(c);
        found_eof = 1'b1;
        marker_crc_cmds++;
      end
    end

    for (int i = 0; i < 8; i++) begin
      pending_cmds.push_back(make_cmd(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
    end
    wait_drained();

    for (int phase = 0; phase < 2; phase++) begin
      for (int i = 0; i < 125; i++) begin
        pending_cmds.push_back(make_cmd(random_byte(), random_byte(), random_byte(),
                                        random_byte()));
      end
      wait_drained();
    end

    repeat (30) @(posedge clk);
    $display("Sent %0d commands (%0d with a checksum equal to a marker), checked %0d words,",
             accepted_cmds, marker_crc_cmds, checked_words);
    $display("with random bursts and stalls, one long output hold-off and full drain pauses.");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
